// ===== rtl/core/u8sd_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CP_BITS    = 21;
  localparam int BR_BITS    = 16;

  localparam logic [CP_BITS-1:0] REPL_CHAR  = 21'h00FFFD;
  localparam logic [7:0]         ASCII_MAX  = 8'h7F;
  localparam logic [7:0]         LEAD_MIN   = 8'hC2;
  localparam logic [7:0]         LEAD_MAX   = 8'hF4;
  localparam logic [7:0]         LEAD3_MIN  = 8'hE0;
  localparam logic [7:0]         LEAD4_MIN  = 8'hF0;
  localparam logic [7:0]         CONT_MASK  = 8'h3F;
  localparam logic [7:0]         LEAD2_MASK = 8'h1F;
  localparam logic [7:0]         LEAD3_MASK = 8'h0F;
  localparam logic [7:0]         LEAD4_MASK = 8'h07;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    logic               replaced;
    logic [BR_BITS-1:0] bytes_read;
  } res_t;

  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    logic               replaced;
  } cp_chk_t;

  // surrogates and values above 10FFFF become U+FFFD
  function automatic cp_chk_t check_cp(input logic [CP_BITS-1:0] v);
    cp_chk_t r;
    r.code_point = v;
    r.replaced   = 1'b0;
    if ((v >= 21'h00D800 && v <= 21'h00DFFF) || v > 21'h10FFFF) begin
      r.code_point = REPL_CHAR;
      r.replaced   = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/u8sd_in_stage.sv =====
// Input register stage: holds one accepted byte until the decoder takes it.
module u8sd_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  u8sd_pkg::in_word_t in_word,
  output logic               held_valid,
  output u8sd_pkg::in_word_t held_word,
  input  logic               take
);

  logic full;

  assign in_ready   = !full || take;
  assign held_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_word <= in_word;
    end
  end

endmodule

// ===== rtl/core/u8sd_decode.sv =====
// Decoder state and per-byte decode logic.
module u8sd_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  u8sd_pkg::in_word_t word,
  output logic               has_res,
  output u8sd_pkg::res_t     res
);

  localparam logic [u8sd_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [1:0]                        pending_count, pending_count_next;
  logic [u8sd_pkg::CP_BITS-1:0]      partial_value, partial_value_next;
  logic [u8sd_pkg::COUNT_BITS-1:0]   consumed_count, consumed_count_next;

  logic [u8sd_pkg::COUNT_BITS-1:0]   cnt_rep;
  logic [u8sd_pkg::BR_BITS-1:0]      br_val;
  logic [u8sd_pkg::CP_BITS-1:0]      emit_val;
  logic                              emit_force_repl;
  logic [1:0]                        pend_after;
  logic [u8sd_pkg::CP_BITS-1:0]      pv_after;
  logic [u8sd_pkg::CP_BITS-1:0]      pv_shift;
  u8sd_pkg::cp_chk_t                 chk;
  logic [7:0]                        b;

  assign b        = word.in_byte;
  assign pv_shift = {partial_value[u8sd_pkg::CP_BITS-7:0], b[5:0] & u8sd_pkg::CONT_MASK[5:0]};

  always_comb begin
    has_res             = 1'b0;
    emit_val            = partial_value;
    emit_force_repl     = 1'b0;
    cnt_rep             = consumed_count;
    pend_after          = pending_count;
    pv_after            = partial_value;
    pending_count_next  = pending_count;
    partial_value_next  = partial_value;
    consumed_count_next = consumed_count;
    if (b == 8'h00) begin
      // string terminator: flush open sequence, not counted
      has_res             = (pending_count != 2'd0);
      pending_count_next  = 2'd0;
      partial_value_next  = '0;
      consumed_count_next = '0;
    end else begin
      if (consumed_count != COUNT_MAX) begin
        cnt_rep = consumed_count + 1'b1;
      end
      if (pending_count != 2'd0) begin
        pend_after = pending_count - 2'd1;
        pv_after   = pv_shift;
        if (pending_count == 2'd1) begin
          has_res  = 1'b1;
          emit_val = pv_shift;
          pv_after = '0;
        end
      end else if (b <= u8sd_pkg::ASCII_MAX) begin
        has_res  = 1'b1;
        emit_val = {13'd0, b & u8sd_pkg::ASCII_MAX};
      end else if (b < u8sd_pkg::LEAD_MIN || b > u8sd_pkg::LEAD_MAX) begin
        has_res         = 1'b1;
        emit_force_repl = 1'b1;
      end else if (b < u8sd_pkg::LEAD3_MIN) begin
        pv_after   = {13'd0, b & u8sd_pkg::LEAD2_MASK};
        pend_after = 2'd1;
      end else if (b < u8sd_pkg::LEAD4_MIN) begin
        pv_after   = {13'd0, b & u8sd_pkg::LEAD3_MASK};
        pend_after = 2'd2;
      end else begin
        pv_after   = {13'd0, b & u8sd_pkg::LEAD4_MASK};
        pend_after = 2'd3;
      end
      if (word.last_byte) begin
        if (pend_after != 2'd0) begin
          has_res  = 1'b1;
          emit_val = pv_after;
        end
        pending_count_next  = 2'd0;
        partial_value_next  = '0;
        consumed_count_next = '0;
      end else begin
        pending_count_next  = pend_after;
        partial_value_next  = pv_after;
        consumed_count_next = cnt_rep;
      end
    end
  end

  always_comb begin
    chk            = u8sd_pkg::check_cp(emit_val);
    res.code_point = emit_force_repl ? u8sd_pkg::REPL_CHAR : chk.code_point;
    res.replaced   = emit_force_repl | chk.replaced;
    res.bytes_read = br_val;
  end

  generate
    if (u8sd_pkg::COUNT_BITS >= u8sd_pkg::BR_BITS) begin : g_br_trunc
      assign br_val = cnt_rep[u8sd_pkg::BR_BITS-1:0];
    end else begin : g_br_ext
      assign br_val = {{(u8sd_pkg::BR_BITS-u8sd_pkg::COUNT_BITS){1'b0}}, cnt_rep};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count  <= 2'd0;
      partial_value  <= '0;
      consumed_count <= '0;
    end else if (fire) begin
      pending_count  <= pending_count_next;
      partial_value  <= partial_value_next;
      consumed_count <= consumed_count_next;
    end
  end

endmodule

// ===== rtl/core/u8sd_out_stage.sv =====
// Result register: holds one decoded word until the sink takes it.
module u8sd_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  u8sd_pkg::res_t res_in,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output u8sd_pkg::res_t res_out
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== rtl/core/utf8_stream_decoder_top.sv =====
// Top level of the byte-serial UTF-8 stream decoder.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: in_byte, tlast: last_byte
//  m_*      out  m_tvalid/m_tready  tdata: code_point, bytes_read; tuser: replaced
//
// One byte per cycle sustained unless m_tready stalls; a byte's result passes the input
// register, then is decoded into the result register that drives m_*.
// The decode state loop (pending count, partial value, byte count) updates on each byte it takes.
// rst is synchronous and clears the valid flags and decode state; the string starts empty.
// A stalled m_tready holds the result and, once the input register is full, s_tready.
module utf8_stream_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [20:0] code_point, [36:21] bytes_read, [39:37] zero
  output logic [0:0]  m_tuser    // [0] replaced
);

  u8sd_pkg::in_word_t in_word;
  u8sd_pkg::in_word_t held_word;
  u8sd_pkg::res_t     res_d;
  u8sd_pkg::res_t     res_q;
  logic               held_valid;
  logic               has_res;
  logic               can_load;
  logic               fire;

  assign in_word.in_byte   = s_tdata;
  assign in_word.last_byte = s_tlast;
  assign fire              = held_valid && can_load;

  u8sd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_word    (in_word),
    .held_valid (held_valid),
    .held_word  (held_word),
    .take       (fire)
  );

  u8sd_decode u_dec (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .word    (held_word),
    .has_res (has_res),
    .res     (res_d)
  );

  u8sd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && has_res),
    .res_in    (res_d),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_out   (res_q)
  );

  assign m_tdata = {3'b000, res_q.bytes_read, res_q.code_point};
  assign m_tuser = res_q.replaced;

endmodule
